// ===== design/tgc_pkg.sv =====
package tgc_pkg;

  // Screen geometry in pixels.
  localparam int SCREEN_WIDTH  = 466;
  localparam int SCREEN_HEIGHT = 466;

  localparam logic [9:0] CENTER_X = 10'(SCREEN_WIDTH / 2);
  localparam logic [9:0] CENTER_Y = 10'(SCREEN_HEIGHT / 2);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SWIPE_MIN_PX    = 3'd0,
    REG_SWIPE_MAX_MS    = 3'd1,
    REG_TAP_MAX_PX      = 3'd2,
    REG_TAP_MAX_MS      = 3'd3,
    REG_LONG_TAP_MS     = 3'd4,
    REG_LONG_TAP_MAX_PX = 3'd5,
    REG_CENTER_RADIUS   = 3'd6
  } reg_idx_t;

  // Configuration reset values.
  localparam logic [9:0]  SWIPE_MIN_PX_RST    = 10'd32;
  localparam logic [15:0] SWIPE_MAX_MS_RST    = 16'd900;
  localparam logic [9:0]  TAP_MAX_PX_RST      = 10'd12;
  localparam logic [15:0] TAP_MAX_MS_RST      = 16'd650;
  localparam logic [15:0] LONG_TAP_MS_RST     = 16'd480;
  localparam logic [9:0]  LONG_TAP_MAX_PX_RST = 10'd48;
  localparam logic [9:0]  CENTER_RADIUS_RST   = 10'd150;

  // Gesture codes.
  typedef enum logic [2:0] {
    KIND_TAP   = 3'd0,
    KIND_LONG  = 3'd1,
    KIND_LEFT  = 3'd2,
    KIND_RIGHT = 3'd3,
    KIND_UP    = 3'd4,
    KIND_DOWN  = 3'd5
  } kind_t;

  // One touch poll.
  typedef struct packed {
    logic        touch_present;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [31:0] time_ms;
  } in_item_t;

  // One gesture.
  typedef struct packed {
    kind_t      gesture_kind;
    logic [9:0] event_x;
    logic [9:0] event_y;
  } out_item_t;

endpackage

// ===== design/touch_gesture_classifier_top.sv =====
// Touch gesture classifier.
//
// The input channel carries one touch poll per transaction (finger present,
// x, y, millisecond timestamp). The output channel carries zero or one
// gesture per poll: tap, long tap, or a swipe in one of four directions.
// Both channels use valid/stall; a transaction completes on a clock edge with
// valid high and stall low. The user must write configuration registers
// through cfg_we/cfg_idx/cfg_data only while no poll is in flight; not enforced.
//
// A poll is captured in an input register, then classified into the result
// register, from which its gesture is offered on the output. One poll is
// accepted every cycle unless a stalled gesture holds the result register;
// the single classification step between the two registers sets that rate.
// When the receiver stalls, the result register holds its gesture and the
// input register keeps at most one poll; in_stall rises only while both are
// full. Synchronous reset drops any pending poll or gesture, ends any held
// touch and restores the configuration defaults.
module touch_gesture_classifier_top
  import tgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [9:0]  swipe_min_px;
  logic [15:0] swipe_max_ms;
  logic [9:0]  tap_max_px;
  logic [15:0] tap_max_ms;
  logic [15:0] long_tap_ms;
  logic [9:0]  long_tap_max_px;
  logic [9:0]  center_radius;

  // Touch tracking state.
  logic        touch_down;
  logic        swipe_done;
  logic [31:0] press_time;
  logic [9:0]  start_x;
  logic [9:0]  start_y;
  logic [9:0]  recent_x;
  logic [9:0]  recent_y;
  logic [9:0]  max_dx;
  logic [9:0]  max_dy;
  logic [20:0] center_dist2;

  // Pipeline registers.
  logic        in_vld;
  in_item_t    in_reg;

  logic        advance;
  logic        process;

  logic [31:0] dt;
  logic [9:0]  abs_x;
  logic [9:0]  abs_y;
  logic [9:0]  max_dx_next;
  logic [9:0]  max_dy_next;
  logic [9:0]  sel_dx;
  logic [9:0]  sel_dy;
  logic [9:0]  ev_x;
  logic [9:0]  ev_y;
  logic [12:0] dx_x5;
  logic [12:0] dy_x5;
  logic [12:0] dx_x8;
  logic [12:0] dy_x8;
  logic        horiz;
  logic        vert;
  logic        swipe_hit;
  kind_t       swipe_kind;
  logic [9:0]  cdx;
  logic [9:0]  cdy;
  logic [19:0] csq_x;
  logic [19:0] csq_y;
  logic [20:0] dist2_next;
  logic [19:0] radius2;
  logic        long_hit;
  logic        tap_hit;
  logic        emit;
  kind_t       emit_kind;
  logic        swipe_done_next;

  // The input register moves on whenever the result register is free.
  assign advance  = !out_valid || !out_stall;
  assign process  = in_vld && advance;
  assign in_stall = in_vld && !advance;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      swipe_min_px    <= SWIPE_MIN_PX_RST;
      swipe_max_ms    <= SWIPE_MAX_MS_RST;
      tap_max_px      <= TAP_MAX_PX_RST;
      tap_max_ms      <= TAP_MAX_MS_RST;
      long_tap_ms     <= LONG_TAP_MS_RST;
      long_tap_max_px <= LONG_TAP_MAX_PX_RST;
      center_radius   <= CENTER_RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SWIPE_MIN_PX:    swipe_min_px    <= cfg_data[9:0];
        REG_SWIPE_MAX_MS:    swipe_max_ms    <= cfg_data;
        REG_TAP_MAX_PX:      tap_max_px      <= cfg_data[9:0];
        REG_TAP_MAX_MS:      tap_max_ms      <= cfg_data;
        REG_LONG_TAP_MS:     long_tap_ms     <= cfg_data;
        REG_LONG_TAP_MAX_PX: long_tap_max_px <= cfg_data[9:0];
        REG_CENTER_RADIUS:   center_radius   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_stall) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg <= in_data;
    end
  end

  // Elapsed time and excursion from the start point.
  assign dt    = in_reg.time_ms - press_time;
  assign abs_x = (in_reg.pos_x > start_x) ? in_reg.pos_x - start_x : start_x - in_reg.pos_x;
  assign abs_y = (in_reg.pos_y > start_y) ? in_reg.pos_y - start_y : start_y - in_reg.pos_y;
  assign max_dx_next = (abs_x > max_dx) ? abs_x : max_dx;
  assign max_dy_next = (abs_y > max_dy) ? abs_y : max_dy;

  // A held poll judges the updated excursion at its own point; a release
  // judges the stored excursion at the last held point.
  assign sel_dx = in_reg.touch_present ? max_dx_next : max_dx;
  assign sel_dy = in_reg.touch_present ? max_dy_next : max_dy;
  assign ev_x   = in_reg.touch_present ? in_reg.pos_x : recent_x;
  assign ev_y   = in_reg.touch_present ? in_reg.pos_y : recent_y;

  // Dominant axis test: major*5 >= minor*8.
  assign dx_x5 = {1'b0, sel_dx, 2'b00} + {3'b000, sel_dx};
  assign dy_x5 = {1'b0, sel_dy, 2'b00} + {3'b000, sel_dy};
  assign dx_x8 = {sel_dx, 3'b000};
  assign dy_x8 = {sel_dy, 3'b000};
  assign horiz = (sel_dx >= swipe_min_px) && (dx_x5 >= dy_x8);
  assign vert  = (sel_dy >= swipe_min_px) && (dy_x5 >= dx_x8);
  assign swipe_hit = horiz || vert;

  always_comb begin
    if (horiz && (!vert || sel_dx >= sel_dy)) begin
      swipe_kind = (ev_x > start_x) ? KIND_RIGHT : KIND_LEFT;
    end else begin
      swipe_kind = (ev_y > start_y) ? KIND_DOWN : KIND_UP;
    end
  end

  // Squared distance of a new start point from the screen center.
  assign cdx = (in_reg.pos_x >= CENTER_X) ? in_reg.pos_x - CENTER_X : CENTER_X - in_reg.pos_x;
  assign cdy = (in_reg.pos_y >= CENTER_Y) ? in_reg.pos_y - CENTER_Y : CENTER_Y - in_reg.pos_y;
  assign csq_x = {10'd0, cdx} * {10'd0, cdx};
  assign csq_y = {10'd0, cdy} * {10'd0, cdy};
  assign dist2_next = {1'b0, csq_x} + {1'b0, csq_y};
  assign radius2 = {10'd0, center_radius} * {10'd0, center_radius};

  // Release classification terms.
  assign long_hit = (dt >= {16'd0, long_tap_ms}) && (max_dx <= long_tap_max_px) &&
                    (max_dy <= long_tap_max_px) && (center_dist2 <= {1'b0, radius2});
  assign tap_hit  = (dt <= {16'd0, tap_max_ms}) && (max_dx <= tap_max_px) &&
                    (max_dy <= tap_max_px);

  // Gesture decision for the poll in the input register.
  always_comb begin
    emit            = 1'b0;
    emit_kind       = swipe_kind;
    swipe_done_next = swipe_done;
    if (touch_down) begin
      if (in_reg.touch_present) begin
        if (!swipe_done && dt <= {16'd0, swipe_max_ms} && swipe_hit) begin
          emit            = 1'b1;
          swipe_done_next = 1'b1;
        end
      end else if (long_hit) begin
        emit      = 1'b1;
        emit_kind = KIND_LONG;
      end else if (!swipe_done) begin
        if (tap_hit) begin
          emit      = 1'b1;
          emit_kind = KIND_TAP;
        end else if (dt <= {16'd0, swipe_max_ms} && swipe_hit) begin
          emit            = 1'b1;
          swipe_done_next = 1'b1;
        end
      end
    end
  end

  // Touch control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      touch_down <= 1'b0;
      swipe_done <= 1'b0;
    end else if (process) begin
      if (!touch_down) begin
        if (in_reg.touch_present) begin
          touch_down <= 1'b1;
          swipe_done <= 1'b0;
        end
      end else begin
        touch_down <= in_reg.touch_present;
        swipe_done <= swipe_done_next;
      end
    end
  end

  // Touch geometry state.
  always_ff @(posedge clk) begin
    if (process && in_reg.touch_present) begin
      recent_x <= in_reg.pos_x;
      recent_y <= in_reg.pos_y;
      if (!touch_down) begin
        press_time   <= in_reg.time_ms;
        start_x      <= in_reg.pos_x;
        start_y      <= in_reg.pos_y;
        max_dx       <= '0;
        max_dy       <= '0;
        center_dist2 <= dist2_next;
      end else begin
        max_dx <= max_dx_next;
        max_dy <= max_dy_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= process && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      out_data.gesture_kind <= emit_kind;
      out_data.event_x      <= ev_x;
      out_data.event_y      <= ev_y;
    end
  end

endmodule

// ===== design/tgc_checker.sv =====
module tgc_checker
  import tgc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Reset leaves no gesture pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("gesture pending after reset");

  // Input back-pressure comes only from a stalled result.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  // A fresh gesture needs an earlier poll taken on the input.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("gesture appeared without a poll");

  // A stalled gesture holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled gesture changed");

endmodule

bind touch_gesture_classifier_top tgc_checker u_tgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
